@@ src/mefb_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants of the mesh edge face builder.
// No dependencies; imported by all source files but mefb_if and mefb_sqrt.
package mefb_pkg;

    localparam int FACE_BITS  = 13;
    localparam int COUNT_BITS = 14;
    localparam int CELL_BITS  = 16;
    localparam int EPOCH_BITS = 8;
    localparam int MUL_W      = 34;

    localparam logic [COUNT_BITS-1:0] FACE_LIMIT = 14'd8192;
    localparam logic [31:0] HASH_MUL_HI = 32'h9E37_79B9;
    localparam logic [31:0] HASH_MUL_LO = 32'h7F4A_7C15;

    typedef struct packed {
        logic rd_en;
        logic wr_en;
        logic new_epoch;
    } tbl_ctrl_t;

    typedef struct packed {
        logic busy;
        logic hit;
    } tbl_stat_t;

    typedef struct packed {
        logic start;
        logic long_mode;
    } div_req_t;

    typedef struct packed {
        logic [FACE_BITS-1:0] face_id;
        logic                 new_face;
        logic [15:0]          vertex_low;
        logic [15:0]          vertex_high;
        logic [CELL_BITS-1:0] cell_index;
        logic signed [31:0]   mid_x;
        logic signed [31:0]   mid_y;
        logic [31:0]          face_length;
        logic signed [15:0]   normal_x;
        logic signed [15:0]   normal_y;
        logic                 last_of_cell;
        logic                 table_full;
    } face_res_t;

endpackage

@@ src/mefb_if.sv @@
`timescale 1ns / 1ps
// Valid/ready channel interfaces for triangle items and face results.
// Depends on nothing; used by the top level, the checker and the testbench.
interface mefb_tri_if;
    logic               valid;
    logic               ready;
    logic               first_cell;
    logic [15:0]        vertex_id_0;
    logic [15:0]        vertex_id_1;
    logic [15:0]        vertex_id_2;
    logic signed [31:0] pos_x_0;
    logic signed [31:0] pos_y_0;
    logic signed [31:0] pos_x_1;
    logic signed [31:0] pos_y_1;
    logic signed [31:0] pos_x_2;
    logic signed [31:0] pos_y_2;

    modport source (
        output valid, first_cell, vertex_id_0, vertex_id_1, vertex_id_2,
        output pos_x_0, pos_y_0, pos_x_1, pos_y_1, pos_x_2, pos_y_2,
        input  ready
    );
    modport sink (
        input  valid, first_cell, vertex_id_0, vertex_id_1, vertex_id_2,
        input  pos_x_0, pos_y_0, pos_x_1, pos_y_1, pos_x_2, pos_y_2,
        output ready
    );
endinterface

interface mefb_face_if;
    logic               valid;
    logic               ready;
    logic [12:0]        face_id;
    logic               new_face;
    logic [15:0]        vertex_low;
    logic [15:0]        vertex_high;
    logic [15:0]        cell_index;
    logic signed [31:0] mid_x;
    logic signed [31:0] mid_y;
    logic [31:0]        face_length;
    logic signed [15:0] normal_x;
    logic signed [15:0] normal_y;
    logic               last_of_cell;
    logic               table_full;

    modport source (
        output valid, face_id, new_face, vertex_low, vertex_high, cell_index,
        output mid_x, mid_y, face_length, normal_x, normal_y, last_of_cell,
        output table_full,
        input  ready
    );
    modport sink (
        input  valid, face_id, new_face, vertex_low, vertex_high, cell_index,
        input  mid_x, mid_y, face_length, normal_x, normal_y, last_of_cell,
        input  table_full,
        output ready
    );
endinterface

@@ src/mefb_edge_table.sv @@
`timescale 1ns / 1ps
// Hashed edge table memory with epoch marks and a clearing pass.
// Depends on mefb_pkg.
module mefb_edge_table #(
    parameter int DEPTH    = 8192,
    parameter int KEY_BITS = 32
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  mefb_pkg::tbl_ctrl_t          ctrl,
    input  logic [$clog2(DEPTH)-1:0]     rd_addr,
    input  logic [$clog2(DEPTH)-1:0]     wr_addr,
    input  logic [KEY_BITS-1:0]          wr_key,
    input  logic [mefb_pkg::FACE_BITS-1:0] wr_face,
    output mefb_pkg::tbl_stat_t          stat,
    output logic [KEY_BITS-1:0]          rd_key,
    output logic [mefb_pkg::FACE_BITS-1:0] rd_face
);
    import mefb_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int EW = EPOCH_BITS + KEY_BITS + FACE_BITS;

    logic [EW-1:0]         mem [DEPTH];
    logic [EW-1:0]         rd_data_reg;
    logic [EPOCH_BITS-1:0] epoch_reg, epoch_next;
    logic                  busy_reg, busy_next;
    logic [AW-1:0]         clr_addr_reg, clr_addr_next;
    logic                  mem_we;
    logic [AW-1:0]         mem_wa;
    logic [EW-1:0]         mem_wd;
    logic [EPOCH_BITS-1:0] epoch_inc;

    assign epoch_inc = epoch_reg + 1'b1;

    always_comb
    begin
        epoch_next    = epoch_reg;
        busy_next     = busy_reg;
        clr_addr_next = clr_addr_reg;
        if (busy_reg)
        begin
            clr_addr_next = clr_addr_reg + 1'b1;
            if (clr_addr_reg == AW'(DEPTH - 1))
            begin
                busy_next = 1'b0;
            end
        end
        else if (ctrl.new_epoch)
        begin
            if (epoch_inc == '0)
            begin
                epoch_next    = EPOCH_BITS'(1);
                busy_next     = 1'b1;
                clr_addr_next = '0;
            end
            else
            begin
                epoch_next = epoch_inc;
            end
        end
    end

    always_comb
    begin
        if (busy_reg)
        begin
            mem_we = 1'b1;
            mem_wa = clr_addr_reg;
            mem_wd = '0;
        end
        else
        begin
            mem_we = ctrl.wr_en;
            mem_wa = wr_addr;
            mem_wd = {epoch_reg, wr_key, wr_face};
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_wa] <= mem_wd;
        end
        if (ctrl.rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            epoch_reg    <= EPOCH_BITS'(1);
            busy_reg     <= 1'b1;
            clr_addr_reg <= '0;
        end
        else
        begin
            epoch_reg    <= epoch_next;
            busy_reg     <= busy_next;
            clr_addr_reg <= clr_addr_next;
        end
    end

    assign stat.busy = busy_reg;
    assign stat.hit  = rd_data_reg[EW-1 -: EPOCH_BITS] == epoch_reg;
    assign rd_key    = rd_data_reg[FACE_BITS +: KEY_BITS];
    assign rd_face   = rd_data_reg[FACE_BITS-1:0];

endmodule

@@ src/mefb_mul.sv @@
`timescale 1ns / 1ps
// Shared signed multiplier with a registered product.
// Depends on mefb_pkg.
module mefb_mul (
    input  logic                              clk,
    input  logic                              en,
    input  logic signed [mefb_pkg::MUL_W-1:0] a,
    input  logic signed [mefb_pkg::MUL_W-1:0] b,
    output logic signed [2*mefb_pkg::MUL_W-1:0] p
);
    import mefb_pkg::*;

    logic signed [2*MUL_W-1:0] p_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_reg <= a * b;
        end
    end

    assign p = p_reg;

endmodule

@@ src/mefb_sqrt.sv @@
`timescale 1ns / 1ps
// Iterative integer square root of a 64-bit value, one bit pair per cycle.
// Depends on nothing beyond the house style.
module mefb_sqrt (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] radicand,
    output logic        done,
    output logic [31:0] root
);
    logic [63:0] n_reg, n_next;
    logic [63:0] r_reg, r_next;
    logic [63:0] b_reg, b_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [63:0] rb;

    assign rb = r_reg + b_reg;

    always_comb
    begin
        n_next    = n_reg;
        r_next    = r_reg;
        b_next    = b_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            n_next    = radicand;
            r_next    = '0;
            b_next    = 64'h4000_0000_0000_0000;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (n_reg >= rb)
            begin
                n_next = n_reg - rb;
                r_next = (r_reg >> 1) + b_reg;
            end
            else
            begin
                r_next = r_reg >> 1;
            end
            b_next   = b_reg >> 2;
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == 6'd31)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg   <= n_next;
        r_reg   <= r_next;
        b_reg   <= b_next;
        cnt_reg <= cnt_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    assign done = done_reg;
    assign root = r_reg[31:0];

endmodule

@@ src/mefb_div.sv @@
`timescale 1ns / 1ps
// Restoring divider for the normal components.
// Depends on mefb_pkg.
module mefb_div (
    input  logic                clk,
    input  logic                rst_n,
    input  mefb_pkg::div_req_t  req,
    input  logic [47:0]         numerator,
    input  logic [32:0]         divisor,
    output logic                done,
    output logic [31:0]         quotient
);
    import mefb_pkg::*;

    logic [32:0] rem_reg, rem_next;
    logic [31:0] q_reg, q_next;
    logic [32:0] div_reg, div_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [33:0] trial;
    logic        ge;

    assign trial = {rem_reg, q_reg[31]};
    assign ge    = trial >= {1'b0, div_reg};

    always_comb
    begin
        rem_next  = rem_reg;
        q_next    = q_reg;
        div_next  = div_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start)
        begin
            div_next  = divisor;
            busy_next = 1'b1;
            if (req.long_mode)
            begin
                rem_next = '0;
                q_next   = numerator[31:0];
                cnt_next = 6'd32;
            end
            else
            begin
                rem_next = {1'b0, numerator[47:16]};
                q_next   = {numerator[15:0], 16'd0};
                cnt_next = 6'd16;
            end
        end
        else if (busy_reg)
        begin
            rem_next = ge ? 33'(trial - {1'b0, div_reg}) : trial[32:0];
            q_next   = {q_reg[30:0], ge};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == 6'd1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        q_reg   <= q_next;
        div_reg <= div_next;
        cnt_reg <= cnt_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    assign done     = done_reg;
    assign quotient = q_reg;

endmodule

@@ src/mesh_edge_face_builder_unit.sv @@
`timescale 1ns / 1ps
// Top level of the mesh edge face builder: sequencer, counters, output register.
// Depends on mefb_pkg, mefb_if, mefb_edge_table, mefb_mul, mefb_sqrt and mefb_div.
//
// Each triangle transfer yields three face results, one per edge 0-1, 1-2, 2-0.
// One triangle is handled at a time: it is accepted, then its orientation is
// tested. Each edge is hashed on the shared multiplier, then its home slot and
// any further probe slots are read and checked. A new edge adds the length
// square root, the normalizing shifts, the second square root and two 16-step
// divisions, all on the shared multiplier, root and divider units. A triangle
// also waits while the result channel stalls. The home slot is the hash reduced
// by a mask, so EDGE_TABLE_DEPTH must be a power of two. After reset, and on
// every 255th triangle with first_cell set, the edge table is swept once and no
// triangle is accepted meanwhile. Results wait in an output register, so the
// next edge is worked on while the previous result is still pending.
module mesh_edge_face_builder_unit #(
    parameter int VERTEX_ID_BITS   = 16,
    parameter int EDGE_TABLE_DEPTH = 8192,
    parameter int PROBE_LIMIT      = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    mefb_tri_if.sink    triangle,
    mefb_face_if.source face
);
    import mefb_pkg::*;

    localparam int VW = (VERTEX_ID_BITS < 16) ? VERTEX_ID_BITS : 16;
    localparam int KW = 2 * VERTEX_ID_BITS;
    localparam int AW = $clog2(EDGE_TABLE_DEPTH);
    localparam int PW = (PROBE_LIMIT > 1) ? $clog2(PROBE_LIMIT) : 1;

    localparam logic [4:0] S_IDLE  = 5'd0;
    localparam logic [4:0] S_OR_A  = 5'd1;
    localparam logic [4:0] S_OR_B  = 5'd2;
    localparam logic [4:0] S_OR_C  = 5'd3;
    localparam logic [4:0] S_EDGE  = 5'd4;
    localparam logic [4:0] S_H1    = 5'd5;
    localparam logic [4:0] S_H2    = 5'd6;
    localparam logic [4:0] S_H3    = 5'd7;
    localparam logic [4:0] S_RD    = 5'd9;
    localparam logic [4:0] S_CHK   = 5'd10;
    localparam logic [4:0] S_G0    = 5'd11;
    localparam logic [4:0] S_G1    = 5'd12;
    localparam logic [4:0] S_G2    = 5'd13;
    localparam logic [4:0] S_G3    = 5'd14;
    localparam logic [4:0] S_NORM0 = 5'd15;
    localparam logic [4:0] S_NORM1 = 5'd16;
    localparam logic [4:0] S_N3    = 5'd17;
    localparam logic [4:0] S_N4    = 5'd18;
    localparam logic [4:0] S_N5    = 5'd19;
    localparam logic [4:0] S_N6    = 5'd20;
    localparam logic [4:0] S_N7    = 5'd21;
    localparam logic [4:0] S_OUT   = 5'd22;

    logic [4:0]            state_reg, state_next;
    logic [1:0]            edge_reg, edge_next;
    logic [CELL_BITS-1:0]  cell_count_reg, cell_count_next;
    logic [COUNT_BITS-1:0] face_count_reg, face_count_next;
    logic                  out_valid_reg, out_valid_next;
    face_res_t             out_reg, out_next;
    face_res_t             res_reg, res_next;

    logic [VW-1:0]         vid_reg [3];
    logic signed [31:0]    px_reg [3];
    logic signed [31:0]    py_reg [3];
    logic                  orient_neg_reg, orient_neg_next;
    logic signed [2*MUL_W-1:0] p1_reg, p1_next;
    logic [31:0]           hacc_reg, hacc_next;
    logic [AW-1:0]         slot_reg, slot_next;
    logic [PW-1:0]         probe_reg, probe_next;
    logic [KW-1:0]         key_reg, key_next;
    logic                  dx_neg_reg, dx_neg_next;
    logic                  dy_neg_reg, dy_neg_next;
    logic [31:0]           mx_reg, mx_next;
    logic [31:0]           my_reg, my_next;
    logic [63:0]           sq_reg, sq_next;
    logic [31:0]           sx_reg, sx_next;
    logic [31:0]           sy_reg, sy_next;
    logic [31:0]           m_reg, m_next;
    logic [31:0]           l_reg, l_next;

    logic                  in_xfer;
    logic [1:0]            ia, ib;
    logic signed [32:0]    or_ax, or_ay, or_bx, or_by;
    logic signed [32:0]    dxs, dys, sumx, sumy;
    logic signed [2*MUL_W-1:0] cross_diff;
    logic [VW-1:0]         va, vb, lo_c, hi_c;
    logic [KW-1:0]         key_c;
    logic [63:0]           key_c64;
    logic [63:0]           key64;
    logic [64:0]           len_sum;
    logic [31:0]           hsum;
    logic [15:0]           mag;

    tbl_ctrl_t             tbl_ctrl;
    tbl_stat_t             tbl_stat;
    logic [KW-1:0]         tbl_rd_key;
    logic [FACE_BITS-1:0]  tbl_rd_face;

    logic                  mul_en;
    logic signed [MUL_W-1:0] mul_a, mul_b;
    logic signed [2*MUL_W-1:0] mul_p;

    logic                  sqrt_start, sqrt_done;
    logic [63:0]           sqrt_in;
    logic [31:0]           sqrt_root;

    div_req_t              div_req;
    logic [47:0]           div_num;
    logic [32:0]           div_den;
    logic                  div_done;
    logic [31:0]           div_quo;

    mefb_edge_table #(
        .DEPTH    (EDGE_TABLE_DEPTH),
        .KEY_BITS (KW)
    ) u_table (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (tbl_ctrl),
        .rd_addr (slot_reg),
        .wr_addr (slot_reg),
        .wr_key  (key_reg),
        .wr_face (face_count_reg[FACE_BITS-1:0]),
        .stat    (tbl_stat),
        .rd_key  (tbl_rd_key),
        .rd_face (tbl_rd_face)
    );

    mefb_mul u_mul (
        .clk (clk),
        .en  (mul_en),
        .a   (mul_a),
        .b   (mul_b),
        .p   (mul_p)
    );

    mefb_sqrt u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sqrt_start),
        .radicand (sqrt_in),
        .done     (sqrt_done),
        .root     (sqrt_root)
    );

    mefb_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (div_req),
        .numerator (div_num),
        .divisor   (div_den),
        .done      (div_done),
        .quotient  (div_quo)
    );

    assign triangle.ready = (state_reg == S_IDLE) && !tbl_stat.busy;
    assign in_xfer        = triangle.valid && triangle.ready;

    assign ia = edge_reg;
    assign ib = (edge_reg == 2'd2) ? 2'd0 : edge_reg + 2'd1;

    assign or_ax = 33'(px_reg[0]) - 33'(px_reg[2]);
    assign or_ay = 33'(py_reg[0]) - 33'(py_reg[2]);
    assign or_bx = 33'(px_reg[1]) - 33'(px_reg[2]);
    assign or_by = 33'(py_reg[1]) - 33'(py_reg[2]);
    assign cross_diff = p1_reg - mul_p;

    assign dxs  = 33'(px_reg[ib]) - 33'(px_reg[ia]);
    assign dys  = 33'(py_reg[ib]) - 33'(py_reg[ia]);
    assign sumx = 33'(px_reg[ib]) + 33'(px_reg[ia]);
    assign sumy = 33'(py_reg[ib]) + 33'(py_reg[ia]);

    assign va      = vid_reg[ia];
    assign vb      = vid_reg[ib];
    assign lo_c    = (va < vb) ? va : vb;
    assign hi_c    = (va < vb) ? vb : va;
    assign key_c   = {VERTEX_ID_BITS'(lo_c), VERTEX_ID_BITS'(hi_c)};
    assign key_c64 = 64'(key_c);
    assign key64   = 64'(key_reg);

    assign len_sum = {1'b0, sq_reg} + {1'b0, 64'(mul_p)};
    assign hsum    = hacc_reg + 32'(mul_p);
    assign mag     = div_quo[15:0];

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            vid_reg[0] <= triangle.vertex_id_0[VW-1:0];
            vid_reg[1] <= triangle.vertex_id_1[VW-1:0];
            vid_reg[2] <= triangle.vertex_id_2[VW-1:0];
            px_reg[0]  <= triangle.pos_x_0;
            py_reg[0]  <= triangle.pos_y_0;
            px_reg[1]  <= triangle.pos_x_1;
            py_reg[1]  <= triangle.pos_y_1;
            px_reg[2]  <= triangle.pos_x_2;
            py_reg[2]  <= triangle.pos_y_2;
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        edge_next       = edge_reg;
        cell_count_next = cell_count_reg;
        face_count_next = face_count_reg;
        out_valid_next  = out_valid_reg && !face.ready;
        out_next        = out_reg;
        res_next        = res_reg;
        orient_neg_next = orient_neg_reg;
        p1_next         = p1_reg;
        hacc_next       = hacc_reg;
        slot_next       = slot_reg;
        probe_next      = probe_reg;
        key_next        = key_reg;
        dx_neg_next     = dx_neg_reg;
        dy_neg_next     = dy_neg_reg;
        mx_next         = mx_reg;
        my_next         = my_reg;
        sq_next         = sq_reg;
        sx_next         = sx_reg;
        sy_next         = sy_reg;
        m_next          = m_reg;
        l_next          = l_reg;
        tbl_ctrl        = '0;
        mul_en          = 1'b0;
        mul_a           = '0;
        mul_b           = '0;
        sqrt_start      = 1'b0;
        sqrt_in         = sq_reg;
        div_req         = '0;
        div_num         = '0;
        div_den         = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_xfer)
                begin
                    edge_next = 2'd0;
                    if (triangle.first_cell)
                    begin
                        face_count_next    = '0;
                        cell_count_next    = '0;
                        tbl_ctrl.new_epoch = 1'b1;
                    end
                    state_next = S_OR_A;
                end
            end
            S_OR_A:
            begin
                mul_en     = 1'b1;
                mul_a      = MUL_W'(or_ax);
                mul_b      = MUL_W'(or_by);
                state_next = S_OR_B;
            end
            S_OR_B:
            begin
                p1_next    = mul_p;
                mul_en     = 1'b1;
                mul_a      = MUL_W'(or_ay);
                mul_b      = MUL_W'(or_bx);
                state_next = S_OR_C;
            end
            S_OR_C:
            begin
                orient_neg_next = cross_diff[2*MUL_W-1];
                state_next      = S_EDGE;
            end
            S_EDGE:
            begin
                key_next              = key_c;
                res_next              = '0;
                res_next.vertex_low   = 16'(lo_c);
                res_next.vertex_high  = 16'(hi_c);
                res_next.cell_index   = cell_count_reg;
                res_next.last_of_cell = edge_reg == 2'd2;
                mul_en                = 1'b1;
                mul_a                 = $signed({2'b00, key_c64[31:0]});
                mul_b                 = $signed({2'b00, HASH_MUL_LO});
                state_next            = S_H1;
            end
            S_H1:
            begin
                hacc_next  = mul_p[63:32];
                mul_en     = 1'b1;
                mul_a      = $signed({2'b00, key64[31:0]});
                mul_b      = $signed({2'b00, HASH_MUL_HI});
                state_next = S_H2;
            end
            S_H2:
            begin
                hacc_next  = hsum;
                mul_en     = 1'b1;
                mul_a      = $signed({2'b00, key64[63:32]});
                mul_b      = $signed({2'b00, HASH_MUL_LO});
                state_next = S_H3;
            end
            S_H3:
            begin
                slot_next  = hsum[AW-1:0];
                probe_next = '0;
                state_next = S_RD;
            end
            S_RD:
            begin
                if (!tbl_stat.busy)
                begin
                    tbl_ctrl.rd_en = 1'b1;
                    state_next     = S_CHK;
                end
            end
            S_CHK:
            begin
                if (!tbl_stat.hit)
                begin
                    res_next.new_face = 1'b1;
                    if (face_count_reg < FACE_LIMIT)
                    begin
                        tbl_ctrl.wr_en      = 1'b1;
                        res_next.face_id    = face_count_reg[FACE_BITS-1:0];
                        face_count_next     = face_count_reg + 1'b1;
                    end
                    else
                    begin
                        res_next.table_full = 1'b1;
                    end
                    state_next = S_G0;
                end
                else if (tbl_rd_key == key_reg)
                begin
                    res_next.face_id = tbl_rd_face;
                    state_next       = S_OUT;
                end
                else if (probe_reg == PW'(PROBE_LIMIT - 1))
                begin
                    res_next.new_face   = 1'b1;
                    res_next.table_full = 1'b1;
                    state_next          = S_G0;
                end
                else
                begin
                    probe_next = probe_reg + 1'b1;
                    slot_next  = (slot_reg == AW'(EDGE_TABLE_DEPTH - 1)) ? '0
                                                                         : slot_reg + 1'b1;
                    state_next = S_RD;
                end
            end
            S_G0:
            begin
                dx_neg_next    = dxs[32];
                dy_neg_next    = dys[32];
                mx_next        = dxs[32] ? 32'(-dxs) : dxs[31:0];
                my_next        = dys[32] ? 32'(-dys) : dys[31:0];
                res_next.mid_x = sumx[32:1];
                res_next.mid_y = sumy[32:1];
                mul_en         = 1'b1;
                mul_a          = $signed({2'b00, mx_next});
                mul_b          = $signed({2'b00, mx_next});
                state_next     = S_G1;
            end
            S_G1:
            begin
                sq_next    = 64'(mul_p);
                mul_en     = 1'b1;
                mul_a      = $signed({2'b00, my_reg});
                mul_b      = $signed({2'b00, my_reg});
                state_next = S_G2;
            end
            S_G2:
            begin
                if (len_sum[64])
                begin
                    res_next.face_length = 32'hFFFF_FFFF;
                    state_next           = S_NORM0;
                end
                else
                begin
                    sqrt_start = 1'b1;
                    sqrt_in    = len_sum[63:0];
                    state_next = S_G3;
                end
            end
            S_G3:
            begin
                if (sqrt_done)
                begin
                    res_next.face_length = sqrt_root;
                    state_next           = S_NORM0;
                end
            end
            S_NORM0:
            begin
                sx_next = mx_reg;
                sy_next = my_reg;
                m_next  = (mx_reg > my_reg) ? mx_reg : my_reg;
                if (mx_reg == '0 && my_reg == '0)
                begin
                    state_next = S_OUT;
                end
                else
                begin
                    state_next = S_NORM1;
                end
            end
            S_NORM1:
            begin
                if (m_reg[31:30] != 2'b00)
                begin
                    m_next  = m_reg >> 1;
                    sx_next = sx_reg >> 1;
                    sy_next = sy_reg >> 1;
                end
                else if (!m_reg[29])
                begin
                    m_next  = m_reg << 1;
                    sx_next = sx_reg << 1;
                    sy_next = sy_reg << 1;
                end
                else
                begin
                    mul_en     = 1'b1;
                    mul_a      = $signed({2'b00, sx_reg});
                    mul_b      = $signed({2'b00, sx_reg});
                    state_next = S_N3;
                end
            end
            S_N3:
            begin
                sq_next    = 64'(mul_p);
                mul_en     = 1'b1;
                mul_a      = $signed({2'b00, sy_reg});
                mul_b      = $signed({2'b00, sy_reg});
                state_next = S_N4;
            end
            S_N4:
            begin
                sqrt_start = 1'b1;
                sqrt_in    = len_sum[63:0];
                state_next = S_N5;
            end
            S_N5:
            begin
                if (sqrt_done)
                begin
                    l_next        = sqrt_root;
                    div_req.start = 1'b1;
                    div_num       = 48'({sy_reg, 15'd0}) + 48'(sqrt_root);
                    div_den       = {sqrt_root, 1'b0};
                    state_next    = S_N6;
                end
            end
            S_N6:
            begin
                if (div_done)
                begin
                    res_next.normal_x = (dy_neg_reg ^ orient_neg_reg) ? -$signed(mag)
                                                                      : $signed(mag);
                    div_req.start     = 1'b1;
                    div_num           = 48'({sx_reg, 15'd0}) + 48'(l_reg);
                    div_den           = {l_reg, 1'b0};
                    state_next        = S_N7;
                end
            end
            S_N7:
            begin
                if (div_done)
                begin
                    res_next.normal_y = (!dx_neg_reg ^ orient_neg_reg) ? -$signed(mag)
                                                                       : $signed(mag);
                    state_next        = S_OUT;
                end
            end
            S_OUT:
            begin
                if (!out_valid_reg || face.ready)
                begin
                    out_next       = res_reg;
                    out_valid_next = 1'b1;
                    if (edge_reg == 2'd2)
                    begin
                        cell_count_next = cell_count_reg + 1'b1;
                        state_next      = S_IDLE;
                    end
                    else
                    begin
                        edge_next  = edge_reg + 2'd1;
                        state_next = S_EDGE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        out_reg        <= out_next;
        res_reg        <= res_next;
        orient_neg_reg <= orient_neg_next;
        p1_reg         <= p1_next;
        hacc_reg       <= hacc_next;
        slot_reg       <= slot_next;
        probe_reg      <= probe_next;
        key_reg        <= key_next;
        dx_neg_reg     <= dx_neg_next;
        dy_neg_reg     <= dy_neg_next;
        mx_reg         <= mx_next;
        my_reg         <= my_next;
        sq_reg         <= sq_next;
        sx_reg         <= sx_next;
        sy_reg         <= sy_next;
        m_reg          <= m_next;
        l_reg          <= l_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            edge_reg       <= '0;
            cell_count_reg <= '0;
            face_count_reg <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            edge_reg       <= edge_next;
            cell_count_reg <= cell_count_next;
            face_count_reg <= face_count_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    assign face.valid        = out_valid_reg;
    assign face.face_id      = out_reg.face_id;
    assign face.new_face     = out_reg.new_face;
    assign face.vertex_low   = out_reg.vertex_low;
    assign face.vertex_high  = out_reg.vertex_high;
    assign face.cell_index   = out_reg.cell_index;
    assign face.mid_x        = out_reg.mid_x;
    assign face.mid_y        = out_reg.mid_y;
    assign face.face_length  = out_reg.face_length;
    assign face.normal_x     = out_reg.normal_x;
    assign face.normal_y     = out_reg.normal_y;
    assign face.last_of_cell = out_reg.last_of_cell;
    assign face.table_full   = out_reg.table_full;

    a_face_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        face_count_reg <= FACE_LIMIT)
        else $error("face counter beyond the face limit");

    a_known_no_geometry: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_reg.new_face) |->
        (!out_reg.table_full && out_reg.face_length == '0 && out_reg.normal_x == '0))
        else $error("known edge carries geometry or a full flag");

    a_write_not_clearing: assert property (@(posedge clk) disable iff (!rst_n)
        tbl_ctrl.wr_en |-> (!tbl_stat.busy && state_reg == S_CHK))
        else $error("edge table written outside a probe check");

    a_div_done_expected: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == S_N6 || state_reg == S_N7))
        else $error("divider finished while no state waits on it");

endmodule

@@ verif/mesh_edge_face_builder_checker.sv @@
`timescale 1ns / 1ps
// Checker of the mesh edge face builder: watches both channels, predicts and checks the face results.
// Depends on mefb_pkg and mefb_if; instantiated by mesh_edge_face_builder_unit_tb.
module mesh_edge_face_builder_checker
    import mefb_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    mefb_tri_if   tri_ch,
    mefb_face_if  face_ch,
    output int    fails,
    output int    pending,
    output int    seen,
    output int    full_seen
);

    localparam int DEPTH = 8192;
    localparam int PROBES = 8;

    logic [31:0]          key_mem [DEPTH];
    bit                   slot_used [DEPTH];
    logic [FACE_BITS-1:0] face_mem [DEPTH];
    int                   face_total;
    logic [15:0]          cell_ctr;
    face_res_t            face_queue [$];

    assign pending = face_queue.size();

    function automatic logic [63:0] root64(logic [63:0] n);
        logic [63:0] r;
        logic [63:0] b;
        r = 0;
        b = 64'd1 << 62;
        while (b > n) b = b >> 2;
        while (b != 0)
        begin
            if (n >= r + b)
            begin
                n = n - (r + b);
                r = (r >> 1) + b;
            end
            else
            begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic logic [12:0] home_slot(logic [31:0] key);
        logic [63:0] prod;
        prod = {32'd0, key} * 64'h9E37_79B9_7F4A_7C15;
        return prod[44:32];
    endfunction

    function automatic logic signed [15:0] unit_comp(logic [63:0] mag, bit neg,
                                                      logic [63:0] len);
        logic [63:0] q;
        q = (mag * 64'd32768 + len) / (64'd2 * len);
        return neg ? -q[15:0] : q[15:0];
    endfunction

    task automatic edge_shape(input logic signed [63:0] ax, ay, bx, by, input int orient,
                              inout face_res_t r);
        logic signed [63:0] dx, dy, sum;
        logic [63:0] mx, my, m, sx, sy, l;
        logic [65:0] sq;
        logic signed [15:0] nx, ny;
        dx = bx - ax;
        dy = by - ay;
        mx = dx < 0 ? -dx : dx;
        my = dy < 0 ? -dy : dy;
        sum = ax + bx;
        r.mid_x = 32'(sum >>> 1);
        sum = ay + by;
        r.mid_y = 32'(sum >>> 1);
        sq = {2'b0, mx} * {2'b0, mx} + {2'b0, my} * {2'b0, my};
        if (sq[65:64] != 0)
            l = 64'hFFFF_FFFF;
        else
            l = root64(sq[63:0]);
        r.face_length = l > 64'hFFFF_FFFF ? 32'hFFFF_FFFF : l[31:0];
        nx = 0;
        ny = 0;
        m = mx > my ? mx : my;
        if (m != 0)
        begin
            sx = mx;
            sy = my;
            while (m >= (64'd1 << 30))
            begin
                m = m >> 1;
                sx = sx >> 1;
                sy = sy >> 1;
            end
            while (m < (64'd1 << 29))
            begin
                m = m << 1;
                sx = sx << 1;
                sy = sy << 1;
            end
            l = root64(sx * sx + sy * sy);
            nx = unit_comp(sy, dy < 0, l);
            ny = unit_comp(sx, !(dx < 0), l);
            if (orient < 0)
            begin
                nx = -nx;
                ny = -ny;
            end
        end
        r.normal_x = nx;
        r.normal_y = ny;
    endtask

    task automatic predict_cell();
        logic [15:0] vid [3];
        logic signed [63:0] px [3], py [3];
        logic signed [71:0] cross_val;
        int orient, g, found, empty, s;
        logic [15:0] lo, hi;
        logic [31:0] key;
        face_res_t r;
        if (tri_ch.first_cell)
        begin
            foreach (slot_used[i]) slot_used[i] = 0;
            face_total = 0;
            cell_ctr = 0;
        end
        vid[0] = tri_ch.vertex_id_0;
        vid[1] = tri_ch.vertex_id_1;
        vid[2] = tri_ch.vertex_id_2;
        px[0] = tri_ch.pos_x_0;
        py[0] = tri_ch.pos_y_0;
        px[1] = tri_ch.pos_x_1;
        py[1] = tri_ch.pos_y_1;
        px[2] = tri_ch.pos_x_2;
        py[2] = tri_ch.pos_y_2;
        cross_val = 72'(px[0] - px[2]) * 72'(py[1] - py[2])
                  - 72'(py[0] - py[2]) * 72'(px[1] - px[2]);
        orient = cross_val < 0 ? -1 : (cross_val > 0 ? 1 : 0);
        for (int f = 0; f < 3; f++)
        begin
            g = (f + 1) % 3;
            lo = vid[f] < vid[g] ? vid[f] : vid[g];
            hi = vid[f] < vid[g] ? vid[g] : vid[f];
            key = {lo, hi};
            r = '0;
            r.vertex_low = lo;
            r.vertex_high = hi;
            r.cell_index = cell_ctr;
            r.last_of_cell = (f == 2);
            found = -1;
            empty = -1;
            for (int p = 0; p < PROBES; p++)
            begin
                s = (int'(home_slot(key)) + p) % DEPTH;
                if (!slot_used[s])
                begin
                    empty = s;
                    break;
                end
                if (key_mem[s] == key)
                begin
                    found = s;
                    break;
                end
            end
            if (found >= 0)
            begin
                r.face_id = face_mem[found];
            end
            else
            begin
                r.new_face = 1;
                edge_shape(px[f], py[f], px[g], py[g], orient, r);
                if (empty >= 0 && face_total < DEPTH)
                begin
                    slot_used[empty] = 1;
                    key_mem[empty] = key;
                    face_mem[empty] = face_total[12:0];
                    r.face_id = face_total[12:0];
                    face_total++;
                end
                else
                begin
                    r.table_full = 1;
                end
            end
            face_queue = {face_queue, r};
        end
        cell_ctr = cell_ctr + 1;
    endtask

    task automatic check_field(string nm, logic [63:0] e, logic [63:0] a);
        if (e !== a)
        begin
            fails++;
            $display("%0t: %s expected %0h actual %0h", $time, nm, e, a);
        end
    endtask

    initial
    begin
        fails = 0;
        seen = 0;
        full_seen = 0;
        face_total = 0;
        cell_ctr = 0;
        foreach (slot_used[i]) slot_used[i] = 0;
    end

    always @(posedge clk)
    begin
        face_res_t e;
        if (rst_n && tri_ch.valid && tri_ch.ready)
            predict_cell();
        if (rst_n && face_ch.valid && face_ch.ready)
        begin
            seen++;
            if (face_ch.table_full) full_seen++;
            if (face_queue.size() == 0)
            begin
                fails++;
                $display("%0t: face result with nothing expected, face_id %0h",
                         $time, face_ch.face_id);
            end
            else
            begin
                e = face_queue.pop_front();
                check_field("face_id", e.face_id, face_ch.face_id);
                check_field("new_face", e.new_face, face_ch.new_face);
                check_field("vertex_low", e.vertex_low, face_ch.vertex_low);
                check_field("vertex_high", e.vertex_high, face_ch.vertex_high);
                check_field("cell_index", e.cell_index, face_ch.cell_index);
                check_field("mid_x", e.mid_x, face_ch.mid_x);
                check_field("mid_y", e.mid_y, face_ch.mid_y);
                check_field("face_length", e.face_length, face_ch.face_length);
                check_field("normal_x", e.normal_x, face_ch.normal_x);
                check_field("normal_y", e.normal_y, face_ch.normal_y);
                check_field("last_of_cell", e.last_of_cell, face_ch.last_of_cell);
                check_field("table_full", e.table_full, face_ch.table_full);
            end
        end
    end

endmodule

@@ verif/mesh_edge_face_builder_unit_tb.sv @@
`timescale 1ns / 1ps
// Testbench top of the mesh edge face builder: clock, reset, triangle stimulus, verdict.
// Depends on mefb_pkg, mefb_if, mesh_edge_face_builder_unit and the checker.
module mesh_edge_face_builder_unit_tb;
    import mefb_pkg::*;

    typedef struct {
        bit          first;
        logic [15:0] id [3];
        logic [31:0] x [3];
        logic [31:0] y [3];
    } cell_item_t;

    logic clk;
    logic rst_n;
    int   fails, pending, seen, full_seen;
    int   cells_sent;
    int   burst_left;
    int   stall_left;
    int   stall_mode;
    int   mode_cycles;

    logic [15:0] pool_id [32];
    logic [31:0] pool_x [32];
    logic [31:0] pool_y [32];
    logic [15:0] coll_lo [10];
    logic [15:0] coll_hi [10];

    mefb_tri_if  tri_ch ();
    mefb_face_if face_ch ();

    mesh_edge_face_builder_unit dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .triangle (tri_ch.sink),
        .face     (face_ch.source)
    );

    mesh_edge_face_builder_checker checker_i (
        .clk       (clk),
        .rst_n     (rst_n),
        .tri_ch    (tri_ch),
        .face_ch   (face_ch),
        .fails     (fails),
        .pending   (pending),
        .seen      (seen),
        .full_seen (full_seen)
    );

    initial
    begin
        clk = 0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #20_000_000;
        $display("tb: failure");
        $finish;
    end

    initial
    begin
        face_ch.ready = 0;
        stall_left = 0;
        stall_mode = 0;
        mode_cycles = 0;
    end

    always @(posedge clk)
    begin
        if (mode_cycles == 0)
        begin
            stall_mode <= $urandom_range(0, 2);
            mode_cycles <= $urandom_range(32, 160);
        end
        else
        begin
            mode_cycles <= mode_cycles - 1;
        end
        if (stall_left > 0)
        begin
            face_ch.ready <= 0;
            stall_left <= stall_left - 1;
        end
        else if (stall_mode == 1 && $urandom_range(0, 1) == 0)
        begin
            face_ch.ready <= 0;
        end
        else if (stall_mode == 2 && $urandom_range(0, 15) == 0)
        begin
            face_ch.ready <= 0;
            stall_left <= $urandom_range(1, 40);
        end
        else
        begin
            face_ch.ready <= 1;
        end
    end

    function automatic logic [12:0] slot_of(logic [15:0] lo, logic [15:0] hi);
        logic [63:0] prod;
        prod = {32'd0, lo, hi} * 64'h9E37_79B9_7F4A_7C15;
        return prod[44:32];
    endfunction

    task automatic send_cell(cell_item_t c);
        if (burst_left == 0)
        begin
            tri_ch.valid <= 0;
            repeat ($urandom_range(1, 14)) @(posedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(10, 30)
                                                     : $urandom_range(1, 6);
        end
        burst_left--;
        tri_ch.valid <= 1;
        tri_ch.first_cell <= c.first;
        tri_ch.vertex_id_0 <= c.id[0];
        tri_ch.vertex_id_1 <= c.id[1];
        tri_ch.vertex_id_2 <= c.id[2];
        tri_ch.pos_x_0 <= c.x[0];
        tri_ch.pos_y_0 <= c.y[0];
        tri_ch.pos_x_1 <= c.x[1];
        tri_ch.pos_y_1 <= c.y[1];
        tri_ch.pos_x_2 <= c.x[2];
        tri_ch.pos_y_2 <= c.y[2];
        do @(posedge clk); while (!tri_ch.ready);
        cells_sent++;
    endtask

    task automatic make_cell(output cell_item_t c, input bit first,
                             input logic [15:0] i0, i1, i2,
                             input logic [31:0] x0, y0, x1, y1, x2, y2);
        c.first = first;
        c.id[0] = i0;
        c.id[1] = i1;
        c.id[2] = i2;
        c.x[0] = x0;
        c.y[0] = y0;
        c.x[1] = x1;
        c.y[1] = y1;
        c.x[2] = x2;
        c.y[2] = y2;
    endtask

    initial
    begin
        cell_item_t c;
        int k, a, b, d;
        logic [12:0] target;
        tri_ch.valid = 0;
        tri_ch.first_cell = 0;
        tri_ch.vertex_id_0 = 0;
        tri_ch.vertex_id_1 = 0;
        tri_ch.vertex_id_2 = 0;
        tri_ch.pos_x_0 = 0;
        tri_ch.pos_y_0 = 0;
        tri_ch.pos_x_1 = 0;
        tri_ch.pos_y_1 = 0;
        tri_ch.pos_x_2 = 0;
        tri_ch.pos_y_2 = 0;
        cells_sent = 0;
        burst_left = 0;
        rst_n = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1;

        make_cell(c, 1, 16'h0000, 16'hFFFF, 16'h0001,
                  32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 0, 0);
        send_cell(c);
        send_cell(c);
        make_cell(c, 0, 16'h0001, 16'hFFFF, 16'h0000,
                  0, 0, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000);
        send_cell(c);
        make_cell(c, 0, 10, 11, 12, 32'h0001_0000, 32'h0002_0000,
                  32'h0001_0000, 32'h0002_0000, 32'hFFFF_0000, 32'h0003_8000);
        send_cell(c);
        make_cell(c, 0, 20, 21, 22, 32'h1234_5678, 32'h8765_4321,
                  32'h1234_5678, 32'h8765_4321, 32'h1234_5678, 32'h8765_4321);
        send_cell(c);
        make_cell(c, 0, 30, 31, 32, 0, 0, 32'h0001_0000, 32'h0002_0000,
                  32'h0003_0000, 32'h0006_0000);
        send_cell(c);
        make_cell(c, 0, 40, 41, 42, 0, 0, 32'h0004_0000, 0, 0, 32'h0003_0000);
        send_cell(c);
        make_cell(c, 0, 50, 51, 52, 0, 0, 0, 32'h0003_0000, 32'h0004_0000, 0);
        send_cell(c);
        make_cell(c, 0, 60, 60, 60, 32'h0000_0001, 0, 32'h0000_0003, 32'h0000_0001,
                  32'hFFFF_FFFF, 32'h0000_0002);
        send_cell(c);
        make_cell(c, 0, 16'hFFFF, 16'hFFFE, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                  32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_cell(c);

        // Find more edges than the probe limit that share one home slot, so the probe window overflows.
        k = 0;
        target = slot_of(16'h1000, 16'h8000);
        for (a = 16'h1000; a < 16'h1010 && k < 10; a++)
            for (b = 16'h8000; b <= 16'hFFFF && k < 10; b++)
                if (slot_of(a[15:0], b[15:0]) == target)
                begin
                    coll_lo[k] = a[15:0];
                    coll_hi[k] = b[15:0];
                    k++;
                end
        for (int i = 0; i < k; i++)
        begin
            make_cell(c, i == 0, coll_hi[i], coll_lo[i], 16'(i + 1),
                      $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
            send_cell(c);
        end

        tri_ch.valid <= 0;
        @(posedge clk);
        wait (pending == 0);

        for (int i = 0; i < 32; i++)
        begin
            pool_id[i] = 16'($urandom);
            pool_x[i] = ($urandom_range(0, 7) == 0) ? $urandom
                                                    : 32'($signed($urandom_range(0, 4095)) - 2048) << 12;
            pool_y[i] = ($urandom_range(0, 7) == 0) ? $urandom
                                                    : 32'($signed($urandom_range(0, 4095)) - 2048) << 12;
        end
        for (int n = 0; n < 270; n++)
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                make_cell(c, $urandom_range(0, 15) == 0,
                          16'($urandom), 16'($urandom), 16'($urandom),
                          $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
            end
            else
            begin
                a = $urandom_range(0, 31);
                b = $urandom_range(0, 31);
                d = $urandom_range(0, 31);
                make_cell(c, n % 45 == 0, pool_id[a], pool_id[b], pool_id[d],
                          pool_x[a], pool_y[a], pool_x[b], pool_y[b], pool_x[d], pool_y[d]);
            end
            send_cell(c);
            if (n == 130)
            begin
                tri_ch.valid <= 0;
                @(posedge clk);
                wait (pending == 0);
            end
        end
        tri_ch.valid <= 0;
        @(posedge clk);

        wait (pending == 0);
        repeat (600) @(posedge clk);
        $display("Run covered %0d triangles and %0d face results, %0d of them table full.",
                 cells_sent, seen, full_seen);
        if (fails == 0 && pending == 0)
        begin
            $display("tb: success");
        end
        else
        begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

@@ sim.f @@
src/mefb_pkg.sv
src/mefb_if.sv
src/mefb_edge_table.sv
src/mefb_mul.sv
src/mefb_sqrt.sv
src/mefb_div.sv
src/mesh_edge_face_builder_unit.sv
verif/mesh_edge_face_builder_checker.sv
verif/mesh_edge_face_builder_unit_tb.sv
